### sv/rld_pkg.sv
package rld_pkg;

    localparam int RING_SENSORS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 8;

    localparam int CORDIC_STEPS = 30;
    localparam int SUM_W        = 36;

    localparam longint Q30_ONE         = 64'sd1073741824;
    localparam longint CORDIC_GAIN_Q30 = 64'sd652032875;
    localparam longint ANG_QUARTER     = 64'sd1073741824;

    localparam logic signed [8:0] NONE_ANGLE = 9'sd255;

    localparam longint ATAN_TAB [CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ACC, ST_SCALE, ST_DXS, ST_DXW, ST_DYS, ST_DYW, ST_SQS, ST_SQW, ST_OUT
    } t_state;

    typedef enum logic [1:0] {SQ_IDLE, SQ_MULX, SQ_MULY, SQ_ROOT} t_sq_state;

    typedef enum logic {CO_IDLE, CO_ITER} t_co_state;

    typedef enum logic {DV_IDLE, DV_ITER} t_dv_state;

    // Unit vector of a binary angle (one turn is 2^32) in Q30; evaluated at
    // elaboration to build the sensor direction table.
    function automatic longint unit_vec(input longint ang, input bit want_y);
        longint x;
        longint y;
        longint z;
        longint nx;
        longint ny;
        longint cx;
        longint cy;
        longint quad;
        int     k;
        quad = (ang >>> 30) & 64'sd3;
        if ((ang & 64'sh3FFFFFFF) == 0) begin
            x = Q30_ONE;
            y = 0;
        end else begin
            x = CORDIC_GAIN_Q30;
            y = 0;
            z = ang & 64'sh3FFFFFFF;
            for (k = 0; k < CORDIC_STEPS; k++) begin
                if (z >= 0) begin
                    nx = x - (y >>> k);
                    ny = y + (x >>> k);
                    z  = z - ATAN_TAB[k];
                end else begin
                    nx = x + (y >>> k);
                    ny = y - (x >>> k);
                    z  = z + ATAN_TAB[k];
                end
                x = nx;
                y = ny;
            end
        end
        case (quad)
            64'sd0: begin
                cx = x;
                cy = y;
            end
            64'sd1: begin
                cx = -y;
                cy = x;
            end
            64'sd2: begin
                cx = -x;
                cy = -y;
            end
            default: begin
                cx = y;
                cy = -x;
            end
        endcase
        return want_y ? cy : cx;
    endfunction

    function automatic logic signed [8:0] side_angle(input logic [2:0] bits);
        logic signed [8:0] a;
        unique case (bits)
            3'd0: a = NONE_ANGLE;
            3'd1: a = -9'sd90;
            3'd2: a = 9'sd90;
            3'd3: a = 9'sd0;
            3'd4: a = 9'sd180;
            3'd5: a = -9'sd135;
            3'd6: a = 9'sd135;
            3'd7: a = 9'sd180;
            default: a = NONE_ANGLE;
        endcase
        return a;
    endfunction

endpackage

### sv/rld_div.sv
module rld_div #(
    parameter int NW = 20,
    parameter int DW = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NW-1:0]         i_dividend,
    input  logic [DW-1:0]         i_divisor,
    output rld_pkg::t_unit_stat   o_stat,
    output logic [NW-1:0]         o_quo
);
    localparam int CNTW = $clog2(NW);

    rld_pkg::t_dv_state r_state, n_state;
    logic [NW-1:0]   r_quo;
    logic [DW-1:0]   r_rem;
    logic [CNTW-1:0] r_cnt;
    logic            r_done;

    logic [DW:0] w_sh;
    logic [DW:0] w_dif;
    logic        w_ge;
    logic        w_last;

    // One quotient bit per cycle, dividend shifted in from the top.
    assign w_sh   = {r_rem, r_quo[NW-1]};
    assign w_ge   = (w_sh >= {1'b0, i_divisor});
    assign w_dif  = w_sh - {1'b0, i_divisor};
    assign w_last = (r_cnt == CNTW'(NW - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rld_pkg::DV_IDLE: if (i_start) n_state = rld_pkg::DV_ITER;
            rld_pkg::DV_ITER: if (w_last) n_state = rld_pkg::DV_IDLE;
            default: n_state = rld_pkg::DV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rld_pkg::DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == rld_pkg::DV_ITER) && w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rld_pkg::DV_IDLE && i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_state == rld_pkg::DV_ITER) begin
            r_quo <= {r_quo[NW-2:0], w_ge};
            r_rem <= w_ge ? w_dif[DW-1:0] : w_sh[DW-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_stat.busy = (r_state != rld_pkg::DV_IDLE);
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
endmodule

### sv/rld_sqrt.sv
module rld_sqrt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [15:0]   i_vx,
    input  logic signed [15:0]   i_vy,
    output rld_pkg::t_unit_stat  o_stat,
    output logic [15:0]          o_root
);
    rld_pkg::t_sq_state r_state, n_state;
    logic [31:0] r_s;
    logic [31:0] r_root;
    logic [31:0] r_bit;
    logic        r_done;

    logic signed [15:0] w_op;
    logic signed [31:0] w_sq;
    logic [32:0]        w_trial;
    logic               w_take;

    // A single multiplier squares x, then y.
    assign w_op    = (r_state == rld_pkg::SQ_MULX) ? i_vx : i_vy;
    assign w_sq    = w_op * w_op;
    assign w_trial = {1'b0, r_root} + {1'b0, r_bit};
    assign w_take  = ({1'b0, r_s} >= w_trial);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rld_pkg::SQ_IDLE: if (i_start) n_state = rld_pkg::SQ_MULX;
            rld_pkg::SQ_MULX: n_state = rld_pkg::SQ_MULY;
            rld_pkg::SQ_MULY: n_state = rld_pkg::SQ_ROOT;
            rld_pkg::SQ_ROOT: if (r_bit[0]) n_state = rld_pkg::SQ_IDLE;
            default: n_state = rld_pkg::SQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rld_pkg::SQ_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == rld_pkg::SQ_ROOT) && r_bit[0];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            rld_pkg::SQ_MULX: r_s <= w_sq;
            rld_pkg::SQ_MULY: begin
                r_s    <= r_s + w_sq;
                r_root <= '0;
                r_bit  <= 32'h4000_0000;
            end
            rld_pkg::SQ_ROOT: begin
                if (w_take) begin
                    r_s    <= r_s - w_trial[31:0];
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            default: ;
        endcase
    end

    // Round to nearest: the leftover above root squared exceeds the root.
    assign o_root      = r_root[15:0] + {15'd0, (r_s > r_root)};
    assign o_stat.busy = (r_state != rld_pkg::SQ_IDLE);
    assign o_stat.done = r_done;
endmodule

### sv/rld_cordic.sv
module rld_cordic (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [rld_pkg::SUM_W-1:0]   i_x,
    input  logic signed [rld_pkg::SUM_W-1:0]   i_y,
    output rld_pkg::t_unit_stat                o_stat,
    output logic signed [8:0]                  o_deg
);
    localparam int SW = rld_pkg::SUM_W;
    localparam int XW = SW + 2;
    localparam int ZW = 34;
    localparam int KW = $clog2(rld_pkg::CORDIC_STEPS);
    localparam logic signed [ZW-1:0] QUARTER = ZW'(rld_pkg::ANG_QUARTER);

    rld_pkg::t_co_state r_state, n_state;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic [KW-1:0]        r_k;
    logic                 r_done;

    logic signed [XW-1:0] w_xin;
    logic signed [XW-1:0] w_yin;
    logic signed [XW-1:0] w_xs;
    logic signed [XW-1:0] w_ys;
    logic signed [ZW-1:0] w_at;
    logic                 w_last;
    logic signed [42:0]   w_num;
    logic [42:0]          w_abs;
    logic [42:0]          w_rnd;
    logic [10:0]          w_d;
    logic [8:0]           w_dc;

    assign w_xin  = XW'(i_x);
    assign w_yin  = XW'(i_y);
    assign w_xs   = r_x >>> r_k;
    assign w_ys   = r_y >>> r_k;
    assign w_at   = ZW'(rld_pkg::ATAN_TAB[r_k]);
    assign w_last = (r_k == KW'(rld_pkg::CORDIC_STEPS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rld_pkg::CO_IDLE: if (i_start) n_state = rld_pkg::CO_ITER;
            rld_pkg::CO_ITER: if (w_last) n_state = rld_pkg::CO_IDLE;
            default: n_state = rld_pkg::CO_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rld_pkg::CO_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == rld_pkg::CO_ITER) && w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rld_pkg::CO_IDLE && i_start) begin
            r_k <= '0;
            // Vectors in the left half are turned a quarter first.
            if (!w_xin[XW-1]) begin
                r_x <= w_xin;
                r_y <= w_yin;
                r_z <= '0;
            end else if (!w_yin[XW-1]) begin
                r_x <= w_yin;
                r_y <= -w_xin;
                r_z <= QUARTER;
            end else begin
                r_x <= -w_yin;
                r_y <= w_xin;
                r_z <= -QUARTER;
            end
        end else if (r_state == rld_pkg::CO_ITER) begin
            r_k <= r_k + 1'b1;
            if (!r_y[XW-1]) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end
        end
    end

    // Binary angle to degrees, rounded half away from zero.
    assign w_num = 43'(r_z) * 43'sd360;
    assign w_abs = w_num[42] ? 43'(-w_num) : 43'(w_num);
    assign w_rnd = w_abs + 43'd2147483648;
    assign w_d   = w_rnd[42:32];
    assign w_dc  = (w_d > 11'd180) ? 9'd180 : w_d[8:0];
    assign o_deg = w_num[42] ? -$signed(w_dc) : $signed(w_dc);

    assign o_stat.busy = (r_state != rld_pkg::CO_IDLE);
    assign o_stat.done = r_done;
endmodule

### sv/ring_line_direction_core.sv
// From request to result: the ring sensors are summed into a vector one by one,
// then one shared divider run each for x and y, then multiply and square root;
// the 30-step angle CORDIC runs beside them. A new request is taken only once
// the sequencer is idle again; the result register frees the input.
// Synchronous active-low reset clears the sequencer, the output valid flag and
// the first-detection state.
module ring_line_direction_core #(
    parameter int RING_SENSORS = rld_pkg::RING_SENSORS_DEF,
    parameter int FRAC_BITS    = rld_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [18:0]        i_sensor_mask,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_ring_seen,
    output logic               o_side_seen,
    output logic signed [15:0] o_vector_x,
    output logic signed [15:0] o_vector_y,
    output logic [15:0]        o_magnitude,
    output logic signed [8:0]  o_ring_angle,
    output logic signed [8:0]  o_side_angle,
    output logic               o_first_hit,
    output logic signed [8:0]  o_first_angle
);
    localparam int NRING = (RING_SENSORS < 16) ? RING_SENSORS : 16;
    localparam int IW    = $clog2(NRING);
    localparam int CW    = $clog2(NRING + 1);
    localparam int SW    = rld_pkg::SUM_W;
    localparam int SH    = 30 - FRAC_BITS;
    localparam int PW    = 42;
    localparam int NW    = PW - SH;
    localparam int NONE_MAG_I = ((255 << FRAC_BITS) > 65535) ? 65535 : (255 << FRAC_BITS);
    localparam logic [15:0] NONE_MAG = 16'(NONE_MAG_I);

    // Sensor direction table and the fallback angle for a zero sum.
    logic signed [SW-1:0] w_cx [NRING];
    logic signed [SW-1:0] w_cy [NRING];
    logic signed [8:0]    w_za [NRING];

    for (genvar g = 0; g < NRING; g++) begin : g_dir
        localparam longint ANG = ((longint'(g) <<< 32) + RING_SENSORS / 2) / RING_SENSORS;
        localparam int T0 = 360 * g + 90 * RING_SENSORS;
        localparam int T1 = (T0 > 180 * RING_SENSORS) ? T0 - 360 * RING_SENSORS : T0;
        localparam int ZA = (T1 >= 0) ? (T1 + RING_SENSORS / 2) / RING_SENSORS
                                      : -((-T1 + RING_SENSORS / 2) / RING_SENSORS);
        assign w_cx[g] = SW'(rld_pkg::unit_vec(ANG, 1'b0));
        assign w_cy[g] = SW'(rld_pkg::unit_vec(ANG, 1'b1));
        assign w_za[g] = 9'(ZA);
    end

    rld_pkg::t_state r_state, n_state;

    logic [NRING-1:0]     r_ring;
    logic [2:0]           r_side;
    logic [IW-1:0]        r_idx;
    logic [CW-1:0]        r_cnt;
    logic [IW-1:0]        r_first;
    logic                 r_found;
    logic signed [SW-1:0] r_sx;
    logic signed [SW-1:0] r_sy;
    logic [NW-1:0]        r_nx;
    logic [NW-1:0]        r_ny;
    logic signed [15:0]   r_vx;
    logic signed [15:0]   r_vy;
    logic                 r_prev;
    logic signed [8:0]    r_latch;

    logic                 r_ovalid;
    logic                 r_oring;
    logic                 r_oside;
    logic signed [15:0]   r_ovx;
    logic signed [15:0]   r_ovy;
    logic [15:0]          r_omag;
    logic signed [8:0]    r_oang;
    logic signed [8:0]    r_oside_ang;
    logic                 r_ohit;

    rld_pkg::t_unit_stat  w_div_stat;
    rld_pkg::t_unit_stat  w_sq_stat;
    rld_pkg::t_unit_stat  w_co_stat;
    logic [NW-1:0]        w_quo;
    logic [15:0]          w_root;
    logic signed [8:0]    w_deg;

    logic [SW-1:0]        w_ax;
    logic [SW-1:0]        w_ay;
    logic [PW-1:0]        w_px;
    logic [PW-1:0]        w_py;
    logic                 w_neg;
    logic signed [15:0]   w_vq;
    logic                 w_ring;
    logic                 w_hit;
    logic signed [8:0]    w_ang;
    logic                 w_last;
    logic                 w_load;

    assign w_last = (r_idx == IW'(NRING - 1));
    assign w_ring = (r_cnt != '0);
    assign w_hit  = w_ring && !r_prev;
    assign w_load = (r_state == rld_pkg::ST_OUT) && (!r_ovalid || !i_stall);

    // Dividend is |sum|*100 plus half the divisor, pre-shifted by the Q30 to
    // Q(FRAC_BITS) step so only the sensor count is left to divide by.
    assign w_ax = r_sx[SW-1] ? SW'(-r_sx) : SW'(r_sx);
    assign w_ay = r_sy[SW-1] ? SW'(-r_sy) : SW'(r_sy);
    assign w_px = PW'(w_ax) * PW'(100) + (PW'(r_cnt) << (SH - 1));
    assign w_py = PW'(w_ay) * PW'(100) + (PW'(r_cnt) << (SH - 1));

    assign w_neg = (r_state == rld_pkg::ST_DXW) ? r_sx[SW-1] : r_sy[SW-1];

    always_comb begin
        if (w_neg) begin
            w_vq = (w_quo > NW'(32768)) ? -16'sd32768 : -$signed(w_quo[15:0]);
        end else begin
            w_vq = (w_quo > NW'(32767)) ? 16'sd32767 : $signed(w_quo[15:0]);
        end
    end

    always_comb begin
        if (!w_ring) begin
            w_ang = rld_pkg::NONE_ANGLE;
        end else if (r_sx == '0 && r_sy == '0) begin
            w_ang = w_za[r_first];
        end else begin
            w_ang = w_deg;
        end
    end

    rld_div #(
        .NW(NW),
        .DW(CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    ((r_state == rld_pkg::ST_DXS) || (r_state == rld_pkg::ST_DYS)),
        .i_dividend ((r_state == rld_pkg::ST_DXS) ? r_nx : r_ny),
        .i_divisor  (r_cnt),
        .o_stat     (w_div_stat),
        .o_quo      (w_quo)
    );

    rld_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == rld_pkg::ST_SQS),
        .i_vx    (r_vx),
        .i_vy    (r_vy),
        .o_stat  (w_sq_stat),
        .o_root  (w_root)
    );

    rld_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == rld_pkg::ST_SCALE) && w_ring),
        .i_x     (r_sx),
        .i_y     (r_sy),
        .o_stat  (w_co_stat),
        .o_deg   (w_deg)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rld_pkg::ST_IDLE:  if (i_valid) n_state = rld_pkg::ST_ACC;
            rld_pkg::ST_ACC:   if (w_last) n_state = rld_pkg::ST_SCALE;
            rld_pkg::ST_SCALE: n_state = w_ring ? rld_pkg::ST_DXS : rld_pkg::ST_OUT;
            rld_pkg::ST_DXS:   n_state = rld_pkg::ST_DXW;
            rld_pkg::ST_DXW:   if (w_div_stat.done) n_state = rld_pkg::ST_DYS;
            rld_pkg::ST_DYS:   n_state = rld_pkg::ST_DYW;
            rld_pkg::ST_DYW:   if (w_div_stat.done) n_state = rld_pkg::ST_SQS;
            rld_pkg::ST_SQS:   n_state = rld_pkg::ST_SQW;
            rld_pkg::ST_SQW: begin
                if (!w_sq_stat.busy && !w_co_stat.busy) n_state = rld_pkg::ST_OUT;
            end
            rld_pkg::ST_OUT:   if (w_load) n_state = rld_pkg::ST_IDLE;
            default: n_state = rld_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rld_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_prev   <= 1'b0;
            r_latch  <= rld_pkg::NONE_ANGLE;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ovalid <= 1'b1;
                r_prev   <= w_ring;
                if (w_hit) begin
                    r_latch <= w_ang;
                end else if (!w_ring) begin
                    r_latch <= rld_pkg::NONE_ANGLE;
                end
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            rld_pkg::ST_IDLE: begin
                r_ring  <= i_sensor_mask[NRING-1:0];
                r_side  <= i_sensor_mask[18:16];
                r_idx   <= '0;
                r_cnt   <= '0;
                r_found <= 1'b0;
                r_first <= '0;
                r_sx    <= '0;
                r_sy    <= '0;
                r_vx    <= '0;
                r_vy    <= '0;
            end
            rld_pkg::ST_ACC: begin
                r_idx <= r_idx + 1'b1;
                if (r_ring[r_idx]) begin
                    r_sx  <= r_sx + w_cx[r_idx];
                    r_sy  <= r_sy + w_cy[r_idx];
                    r_cnt <= r_cnt + 1'b1;
                    if (!r_found) begin
                        r_found <= 1'b1;
                        r_first <= r_idx;
                    end
                end
            end
            rld_pkg::ST_SCALE: begin
                r_nx <= w_px[PW-1:SH];
                r_ny <= w_py[PW-1:SH];
            end
            rld_pkg::ST_DXW: if (w_div_stat.done) r_vx <= w_vq;
            rld_pkg::ST_DYW: if (w_div_stat.done) r_vy <= w_vq;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_oring     <= w_ring;
            r_oside     <= (r_side != 3'd0);
            r_ovx       <= r_vx;
            r_ovy       <= r_vy;
            r_omag      <= w_ring ? w_root : NONE_MAG;
            r_oang      <= w_ang;
            r_oside_ang <= rld_pkg::side_angle(r_side);
            r_ohit      <= w_hit;
        end
    end

    assign o_stall       = (r_state != rld_pkg::ST_IDLE);
    assign o_valid       = r_ovalid;
    assign o_ring_seen   = r_oring;
    assign o_side_seen   = r_oside;
    assign o_vector_x    = r_ovx;
    assign o_vector_y    = r_ovy;
    assign o_magnitude   = r_omag;
    assign o_ring_angle  = r_oang;
    assign o_side_angle  = r_oside_ang;
    assign o_first_hit   = r_ohit;
    assign o_first_angle = r_latch;

    a_hit_needs_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_first_hit |-> o_ring_seen)
        else $error("first hit without ring detection");

    a_no_ring_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ring_seen |-> o_ring_angle == rld_pkg::NONE_ANGLE
            && o_vector_x == 16'sd0 && o_vector_y == 16'sd0
            && o_first_angle == rld_pkg::NONE_ANGLE)
        else $error("no-ring result carries ring values");

    a_hit_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_first_hit |-> o_first_angle == o_ring_angle)
        else $error("first angle not latched on first hit");

    a_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rld_pkg::ST_IDLE |-> !w_div_stat.busy && !w_sq_stat.busy)
        else $error("arithmetic unit busy while sequencer idle");
endmodule
